// ----- hdl/sefj_pkg.sv -----
// ----------------------------------------------------------------------------
// sefj_pkg
// Types and pipeline stage map of the spring force and stiffness pipeline.
// ----------------------------------------------------------------------------
package sefj_pkg;

    // stage map
    localparam int ST_SQ       = 1;
    localparam int ST_SUM      = 2;
    localparam int ST_RT0      = 3;
    localparam int RT_BITS     = 34;
    localparam int ST_RT_LAST  = ST_RT0 + RT_BITS - 1;
    localparam int ST_ERR      = ST_RT_LAST + 1;
    localparam int QBITS       = 62;
    localparam int ST_DIV0     = ST_ERR + 1;
    localparam int ST_DIV_LAST = ST_DIV0 + QBITS - 1;
    localparam int ST_F1       = ST_DIV_LAST + 1;
    localparam int ST_F2       = ST_F1 + 1;
    localparam int ST_F3       = ST_F2 + 1;
    localparam int ST_F4       = ST_F3 + 1;
    localparam int ST_F5       = ST_F4 + 1;
    localparam int NST         = ST_F5 + 1;

    // block entry index pairs: xx xy xz yy yz zz
    localparam int PR_R [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PR_S [6] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic [31:0]      k;
        logic [31:0]      l0;
        logic [2:0][63:0] sq;
        logic [65:0]      rem;
        logic [33:0]      root;
        logic             e_neg;
        logic [33:0]      em;
        logic             zero;
        logic [3:0][34:0] drem;
        logic [3:0][61:0] dq;
        logic [67:0]      em2;
        logic [65:0]      epl;
        logic [65:0]      eph;
        logic [31:0]      energy;
        logic [65:0]      a;
        logic [5:0][30:0] pn;
        logic [2:0][63:0] fpl;
        logic [2:0][63:0] fph;
        logic [5:0][61:0] qpl;
        logic [5:0][61:0] qph;
        logic [2:0][31:0] frc;
        logic [5:0]       t_neg;
        logic [5:0][63:0] tm;
        logic [5:0][63:0] bpl;
        logic [5:0][63:0] bph;
        logic [5:0][31:0] blk;
    } pipe_t;

endpackage

// ----- hdl/spring_element_force_jacobian.sv -----
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Length comes from a 34-stage square root, the unit vector and rest ratio from
// four 62-stage restoring dividers; these set the depth.
// Reset clears the stage valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
// spring_element_force_jacobian
// Hookean spring energy, force on the first endpoint and 3x3 stiffness block,
// Q16.16 in and out, fully pipelined.
// ----------------------------------------------------------------------------
module spring_element_force_jacobian
    import sefj_pkg::*;
#(
    parameter int DIM = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               spring_valid,
    output logic               spring_stall,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_z,
    input  logic        [31:0] stiffness,
    input  logic        [31:0] rest_len,
    output logic               result_valid,
    input  logic               result_stall,
    output logic        [31:0] energy,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z,
    output logic signed [31:0] block_xx,
    output logic signed [31:0] block_xy,
    output logic signed [31:0] block_xz,
    output logic signed [31:0] block_yy,
    output logic signed [31:0] block_yz,
    output logic signed [31:0] block_zz,
    output logic               zero_length
);

    pipe_t          stage_reg  [NST];
    pipe_t          stage_next [NST];
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic           en;

    assign en           = !(vld_reg[NST-1] && result_stall);
    assign spring_stall = !en;
    assign vld_next     = {vld_reg[NST-2:0], spring_valid};

    // stage 0: endpoint differences
    always_comb
    begin
        logic signed [32:0] d [3];
        stage_next[0] = '0;
        d[0] = {second_x[31], second_x} - {first_x[31], first_x};
        d[1] = {second_y[31], second_y} - {first_y[31], first_y};
        d[2] = {second_z[31], second_z} - {first_z[31], first_z};
        if (DIM < 3)
        begin
            d[2] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            stage_next[0].dn[i] = d[i][32];
            stage_next[0].dm[i] = d[i][32] ? 32'(-d[i]) : d[i][31:0];
        end
        stage_next[0].k  = stiffness;
        stage_next[0].l0 = rest_len;
    end

    genvar g, ln;
    generate
        for (g = 1; g < NST; g++)
        begin : g_st
            if (g == ST_SQ)
            begin : g_sq
                always_comb
                begin
                    stage_next[g] = stage_reg[g-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        stage_next[g].sq[i] = stage_reg[g-1].dm[i] * stage_reg[g-1].dm[i];
                    end
                end
            end
            else if (g == ST_SUM)
            begin : g_sum
                always_comb
                begin
                    stage_next[g] = stage_reg[g-1];
                    stage_next[g].rem = {2'd0, stage_reg[g-1].sq[0]}
                                      + {2'd0, stage_reg[g-1].sq[1]}
                                      + {2'd0, stage_reg[g-1].sq[2]};
                    stage_next[g].root = '0;
                end
            end
            else if (g >= ST_RT0 && g <= ST_RT_LAST)
            begin : g_rt
                localparam int B = ST_RT_LAST - g;
                always_comb
                begin
                    logic [69:0] trial;
                    stage_next[g] = stage_reg[g-1];
                    trial = ({36'd0, stage_reg[g-1].root} << (B + 1)) + (70'd1 << (2 * B));
                    if ({4'd0, stage_reg[g-1].rem} >= trial)
                    begin
                        stage_next[g].rem     = stage_reg[g-1].rem - trial[65:0];
                        stage_next[g].root[B] = 1'b1;
                    end
                end
            end
            else if (g == ST_ERR)
            begin : g_err
                always_comb
                begin
                    logic [34:0] e;
                    stage_next[g] = stage_reg[g-1];
                    e = {1'b0, stage_reg[g-1].root} - {3'd0, stage_reg[g-1].l0};
                    stage_next[g].e_neg = e[34];
                    stage_next[g].em    = e[34] ? 34'(-e) : e[33:0];
                    stage_next[g].zero  = (stage_reg[g-1].root == '0);
                    stage_next[g].drem  = '0;
                    stage_next[g].dq    = '0;
                end
            end
            else if (g >= ST_DIV0 && g <= ST_DIV_LAST)
            begin : g_div
                localparam int I = ST_DIV_LAST - g;
                logic [3:0] nbit;
                for (ln = 0; ln < 4; ln++)
                begin : g_ln
                    if (I < 30)
                    begin : g_lo
                        assign nbit[ln] = 1'b0;
                    end
                    else if (ln < 3)
                    begin : g_dm
                        assign nbit[ln] = stage_reg[g-1].dm[ln][I-30];
                    end
                    else
                    begin : g_l0
                        assign nbit[ln] = stage_reg[g-1].l0[I-30];
                    end
                end
                always_comb
                begin
                    logic [34:0] sh;
                    logic [99:0] eprod;
                    stage_next[g] = stage_reg[g-1];
                    for (int l = 0; l < 4; l++)
                    begin
                        sh = {stage_reg[g-1].drem[l][33:0], nbit[l]};
                        if (sh >= {1'b0, stage_reg[g-1].root})
                        begin
                            stage_next[g].drem[l]  = sh - {1'b0, stage_reg[g-1].root};
                            stage_next[g].dq[l][I] = 1'b1;
                        end
                        else
                        begin
                            stage_next[g].drem[l] = sh;
                        end
                    end
                    // energy rides alongside the dividers
                    eprod = {stage_reg[g-1].eph, 34'd0} + {34'd0, stage_reg[g-1].epl};
                    if (g == ST_DIV0)
                    begin
                        stage_next[g].em2 = stage_reg[g-1].em * stage_reg[g-1].em;
                    end
                    if (g == ST_DIV0 + 1)
                    begin
                        stage_next[g].epl = stage_reg[g-1].em2[33:0] * stage_reg[g-1].k;
                        stage_next[g].eph = stage_reg[g-1].em2[67:34] * stage_reg[g-1].k;
                    end
                    if (g == ST_DIV0 + 2)
                    begin
                        stage_next[g].energy = (eprod[99:65] != '0) ? '1 : eprod[64:33];
                    end
                end
            end
            else if (g == ST_F1)
            begin : g_f1
                always_comb
                begin
                    logic [61:0] pp;
                    stage_next[g] = stage_reg[g-1];
                    stage_next[g].a = stage_reg[g-1].k * stage_reg[g-1].em;
                    for (int j = 0; j < 6; j++)
                    begin
                        pp = stage_reg[g-1].dq[PR_R[j]][30:0] * stage_reg[g-1].dq[PR_S[j]][30:0];
                        stage_next[g].pn[j] = pp[60:30];
                    end
                end
            end
            else if (g == ST_F2)
            begin : g_f2
                always_comb
                begin
                    stage_next[g] = stage_reg[g-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        stage_next[g].fpl[i] = stage_reg[g-1].a[32:0]  * stage_reg[g-1].dq[i][30:0];
                        stage_next[g].fph[i] = stage_reg[g-1].a[65:33] * stage_reg[g-1].dq[i][30:0];
                    end
                    for (int j = 0; j < 6; j++)
                    begin
                        stage_next[g].qpl[j] = stage_reg[g-1].dq[3][30:0]  * stage_reg[g-1].pn[j];
                        stage_next[g].qph[j] = stage_reg[g-1].dq[3][61:31] * stage_reg[g-1].pn[j];
                    end
                end
            end
            else if (g == ST_F3)
            begin : g_f3
                always_comb
                begin
                    logic [96:0] fp;
                    logic [50:0] fv;
                    logic [50:0] flim;
                    logic        fneg;
                    logic [92:0] qs;
                    logic [62:0] qp;
                    logic [65:0] t;
                    stage_next[g] = stage_reg[g-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        fp   = {stage_reg[g-1].fph[i], 33'd0} + {33'd0, stage_reg[g-1].fpl[i]};
                        fv   = fp[96:46];
                        fneg = stage_reg[g-1].e_neg ^ stage_reg[g-1].dn[i];
                        flim = fneg ? 51'h80000000 : 51'h7FFFFFFF;
                        if (fv > flim)
                        begin
                            fv = flim;
                        end
                        stage_next[g].frc[i] = fneg ? -fv[31:0] : fv[31:0];
                    end
                    for (int j = 0; j < 6; j++)
                    begin
                        qs = {stage_reg[g-1].qph[j], 31'd0} + {31'd0, stage_reg[g-1].qpl[j]};
                        qp = qs[92:30];
                        t  = (stage_reg[g-1].dn[PR_R[j]] != stage_reg[g-1].dn[PR_S[j]])
                           ? -{3'd0, qp} : {3'd0, qp};
                        if (PR_R[j] == PR_S[j])
                        begin
                            t = t + (66'd1 << 30) - {4'd0, stage_reg[g-1].dq[3]};
                        end
                        stage_next[g].t_neg[j] = !t[65] && (t != '0);
                        stage_next[g].tm[j]    = t[65] ? 64'(-t) : t[63:0];
                    end
                end
            end
            else if (g == ST_F4)
            begin : g_f4
                always_comb
                begin
                    stage_next[g] = stage_reg[g-1];
                    for (int j = 0; j < 6; j++)
                    begin
                        stage_next[g].bpl[j] = stage_reg[g-1].k * stage_reg[g-1].tm[j][31:0];
                        stage_next[g].bph[j] = stage_reg[g-1].k * stage_reg[g-1].tm[j][63:32];
                    end
                end
            end
            else
            begin : g_f5
                always_comb
                begin
                    logic [95:0] bp;
                    logic [65:0] bv;
                    logic [65:0] blim;
                    stage_next[g] = stage_reg[g-1];
                    for (int j = 0; j < 6; j++)
                    begin
                        bp   = {stage_reg[g-1].bph[j], 32'd0} + {32'd0, stage_reg[g-1].bpl[j]};
                        bv   = bp[95:30];
                        blim = stage_reg[g-1].t_neg[j] ? 66'h80000000 : 66'h7FFFFFFF;
                        if (bv > blim)
                        begin
                            bv = blim;
                        end
                        stage_next[g].blk[j] = stage_reg[g-1].t_neg[j] ? -bv[31:0] : bv[31:0];
                    end
                    if (stage_reg[g-1].zero)
                    begin
                        stage_next[g].frc = '0;
                        stage_next[g].blk = '0;
                    end
                    if (DIM < 3)
                    begin
                        stage_next[g].frc[2] = '0;
                        stage_next[g].blk[2] = '0;
                        stage_next[g].blk[4] = '0;
                        stage_next[g].blk[5] = '0;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NST; s++)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign result_valid = vld_reg[NST-1];
    assign energy       = stage_reg[NST-1].energy;
    assign force_x      = stage_reg[NST-1].frc[0];
    assign force_y      = stage_reg[NST-1].frc[1];
    assign force_z      = stage_reg[NST-1].frc[2];
    assign block_xx     = stage_reg[NST-1].blk[0];
    assign block_xy     = stage_reg[NST-1].blk[1];
    assign block_xz     = stage_reg[NST-1].blk[2];
    assign block_yy     = stage_reg[NST-1].blk[3];
    assign block_yz     = stage_reg[NST-1].blk[4];
    assign block_zz     = stage_reg[NST-1].blk[5];
    assign zero_length  = stage_reg[NST-1].zero;

endmodule
